[hw/rtl/saia_pkg.sv]
// ----------------------------------------------------------------------------
// saia_pkg: shared types for the shift/add integer ALU
// Opcodes, controller states and the command and status bundles that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
package saia_pkg;

	// Operation codes carried in the low bits of each input item.
	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_SQR = 3'd4,
		OP_POW = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DIV,
		ST_POW_CHECK,
		ST_POW_MULR,
		ST_POW_SQR,
		ST_FINISH
	} state_t;

	// Source written into the result register.
	typedef enum logic [2:0] {
		RES_NONE,
		RES_ADD,
		RES_SUB,
		RES_ACC,
		RES_ONE,
		RES_ZERO
	} res_sel_t;

	// Operand pair fed to the shared shift-add multiplier.
	typedef enum logic [1:0] {
		MUL_AB,
		MUL_AA,
		MUL_RES_BASE,
		MUL_BASE_BASE
	} mul_src_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_src_t mul_src;
		logic     mul_step;
		logic     div_start;
		logic     div_step;
		res_sel_t res_sel;
		logic     base_load;
		logic     e_shift;
		logic     set_dz;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic b_zero;
		logic mul_done;
		logic div_done;
		logic e_zero;
		logic e_lsb;
	} sts_t;

endpackage

[hw/rtl/saia_dpath.sv]
// ----------------------------------------------------------------------------
// saia_dpath: ALU datapath
// Operand registers, a shared shift-add multiplier, a restoring divider
// and the result register, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
module saia_dpath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic [2:0]           opcode,
	input  logic [31:0]          operand_a,
	input  logic [31:0]          operand_b,
	input  logic [31:0]          exponent,
	input  saia_pkg::cmd_t       cmd,
	output saia_pkg::sts_t       sts,
	output logic [31:0]          result_value,
	output logic                 divide_by_zero
);

	localparam int W    = DATA_WIDTH;
	localparam int CntW = $clog2(W + 1);

	logic [2:0]      op_q;
	logic [W-1:0]    a_q, b_q, res_q, base_q;
	logic [W-1:0]    mx_q, my_q, acc_q, rem_q;
	logic [31:0]     e_q;
	logic            dz_q;
	logic [CntW-1:0] cnt_q;

	logic [W-1:0]    a_w, b_w;
	logic [W-1:0]    src_x, src_y;
	logic [W:0]      rem_sh, diff;
	logic            ge;

	// Operands are taken modulo 2^W; the result field is the low 32 bits.
	generate
		if (W >= 32) begin : g_wide
			assign a_w          = {{(W-32){1'b0}}, operand_a};
			assign b_w          = {{(W-32){1'b0}}, operand_b};
			assign result_value = res_q[31:0];
		end else begin : g_narrow
			assign a_w          = operand_a[W-1:0];
			assign b_w          = operand_b[W-1:0];
			assign result_value = {{(32-W){1'b0}}, res_q};
		end
	endgenerate

	assign divide_by_zero = dz_q;

	always_comb begin
		unique case (cmd.mul_src)
			saia_pkg::MUL_AB: begin
				src_x = a_q;
				src_y = b_q;
			end
			saia_pkg::MUL_AA: begin
				src_x = a_q;
				src_y = a_q;
			end
			saia_pkg::MUL_RES_BASE: begin
				src_x = res_q;
				src_y = base_q;
			end
			saia_pkg::MUL_BASE_BASE: begin
				src_x = base_q;
				src_y = base_q;
			end
		endcase
	end

	// One restoring step: bring down the next numerator bit and try the divisor.
	assign rem_sh = {rem_q, mx_q[W-1]};
	assign diff   = rem_sh - {1'b0, b_q};
	assign ge     = ~diff[W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			a_q    <= a_w;
			b_q    <= b_w;
			e_q    <= exponent;
			base_q <= a_w;
			dz_q   <= 1'b0;
		end
		if (cmd.mul_start) begin
			mx_q  <= src_x;
			my_q  <= src_y;
			acc_q <= '0;
		end else if (cmd.div_start) begin
			mx_q  <= a_q;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= CntW'(W);
		end else if (cmd.mul_step) begin
			if (my_q[0]) begin
				acc_q <= acc_q + mx_q;
			end
			mx_q <= mx_q << 1;
			my_q <= my_q >> 1;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			acc_q <= {acc_q[W-2:0], ge};
			mx_q  <= mx_q << 1;
			cnt_q <= cnt_q - CntW'(1);
		end
		case (cmd.res_sel)
			saia_pkg::RES_ADD:  res_q <= a_q + b_q;
			saia_pkg::RES_SUB:  res_q <= a_q - b_q;
			saia_pkg::RES_ACC:  res_q <= acc_q;
			saia_pkg::RES_ONE:  res_q <= {{(W-1){1'b0}}, 1'b1};
			saia_pkg::RES_ZERO: res_q <= '0;
			default:            res_q <= res_q;
		endcase
		if (cmd.base_load) begin
			base_q <= acc_q;
		end
		if (cmd.e_shift) begin
			e_q <= e_q >> 1;
		end
		if (cmd.set_dz) begin
			dz_q <= 1'b1;
		end
	end

	assign sts.op       = saia_pkg::op_t'(op_q);
	assign sts.b_zero   = (b_q == '0);
	assign sts.mul_done = (my_q == '0);
	assign sts.div_done = (cnt_q == '0);
	assign sts.e_zero   = (e_q == '0);
	assign sts.e_lsb    = e_q[0];

endmodule

[hw/rtl/saia_ctrl.sv]
// ----------------------------------------------------------------------------
// saia_ctrl: ALU sequencer
// State machine that decodes the opcode and steps the multiplier and
// divider, including the square-and-multiply loop for power.
// ----------------------------------------------------------------------------
module saia_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	input  saia_pkg::sts_t sts,
	output logic           in_ready,
	output saia_pkg::cmd_t cmd
);

	saia_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= saia_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.mul_start = 1'b0;
		cmd.mul_src   = saia_pkg::MUL_AB;
		cmd.mul_step  = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.res_sel   = saia_pkg::RES_NONE;
		cmd.base_load = 1'b0;
		cmd.e_shift   = 1'b0;
		cmd.set_dz    = 1'b0;
		cmd.out_load  = 1'b0;

		unique case (state_q)
			saia_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = saia_pkg::ST_DECODE;
				end
			end
			saia_pkg::ST_DECODE: begin
				case (sts.op)
					saia_pkg::OP_ADD: begin
						cmd.res_sel = saia_pkg::RES_ADD;
						state_d     = saia_pkg::ST_FINISH;
					end
					saia_pkg::OP_SUB: begin
						cmd.res_sel = saia_pkg::RES_SUB;
						state_d     = saia_pkg::ST_FINISH;
					end
					saia_pkg::OP_MUL: begin
						cmd.mul_start = 1'b1;
						cmd.mul_src   = saia_pkg::MUL_AB;
						state_d       = saia_pkg::ST_MUL;
					end
					saia_pkg::OP_SQR: begin
						cmd.mul_start = 1'b1;
						cmd.mul_src   = saia_pkg::MUL_AA;
						state_d       = saia_pkg::ST_MUL;
					end
					saia_pkg::OP_DIV: begin
						if (sts.b_zero) begin
							cmd.res_sel = saia_pkg::RES_ZERO;
							cmd.set_dz  = 1'b1;
							state_d     = saia_pkg::ST_FINISH;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = saia_pkg::ST_DIV;
						end
					end
					saia_pkg::OP_POW: begin
						cmd.res_sel = saia_pkg::RES_ONE;
						state_d     = saia_pkg::ST_POW_CHECK;
					end
					default: begin
						cmd.res_sel = saia_pkg::RES_ZERO;
						state_d     = saia_pkg::ST_FINISH;
					end
				endcase
			end
			saia_pkg::ST_MUL: begin
				if (sts.mul_done) begin
					cmd.res_sel = saia_pkg::RES_ACC;
					state_d     = saia_pkg::ST_FINISH;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			saia_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.res_sel = saia_pkg::RES_ACC;
					state_d     = saia_pkg::ST_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			saia_pkg::ST_POW_CHECK: begin
				if (sts.e_zero) begin
					state_d = saia_pkg::ST_FINISH;
				end else if (sts.e_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_src   = saia_pkg::MUL_RES_BASE;
					state_d       = saia_pkg::ST_POW_MULR;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_src   = saia_pkg::MUL_BASE_BASE;
					state_d       = saia_pkg::ST_POW_SQR;
				end
			end
			saia_pkg::ST_POW_MULR: begin
				if (sts.mul_done) begin
					cmd.res_sel   = saia_pkg::RES_ACC;
					cmd.mul_start = 1'b1;
					cmd.mul_src   = saia_pkg::MUL_BASE_BASE;
					state_d       = saia_pkg::ST_POW_SQR;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			saia_pkg::ST_POW_SQR: begin
				if (sts.mul_done) begin
					cmd.base_load = 1'b1;
					cmd.e_shift   = 1'b1;
					state_d       = saia_pkg::ST_POW_CHECK;
				end else begin
					cmd.mul_step = 1'b1;
				end
			end
			saia_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = saia_pkg::ST_IDLE;
				end
			end
		endcase
	end

endmodule

[hw/rtl/shift_add_integer_alu.sv]
// ----------------------------------------------------------------------------
// shift_add_integer_alu: unsigned integer ALU built on shift-add and
// restoring shift-subtract
// Add, subtract, unused opcodes and divide by zero finish straight from decode;
// multiply and square step until the remaining multiplier bits are all zero,
// one multiplier bit a cycle on the shift-add unit; divide steps through
// DATA_WIDTH quotient bits, one quotient bit a cycle. Power runs one square
// (and a multiply for every set exponent bit) per exponent bit up to its
// highest set bit, on the same shared multiplier.
// One item is in work at a time; the next is taken once the result sits in
// the output register. Reset is asynchronous and active low; it returns the
// sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module shift_add_integer_alu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input item stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, lowest bit up: opcode[2:0], operand_a[34:3], operand_b[66:35],
	// exponent[98:67], zero padding[103:99]
	input  logic [103:0] s_tdata,
	// Result item stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, lowest bit up: result_value[31:0]
	output logic [31:0]  m_tdata,
	// m_tuser, lowest bit up: divide_by_zero[0]
	output logic         m_tuser
);

	saia_pkg::cmd_t cmd;
	saia_pkg::sts_t sts;

	logic        out_valid_q;
	logic [31:0] out_result_q;
	logic        out_dz_q;
	logic        out_free;
	logic [31:0] dp_result;
	logic        dp_dz;

	// The output register may be refilled in the same cycle as its item is
	// taken, so a finished result never waits behind a consumer that is ready.
	assign out_free = ~out_valid_q | m_tready;

	saia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	saia_dpath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk            (clk),
		.opcode         (s_tdata[2:0]),
		.operand_a      (s_tdata[34:3]),
		.operand_b      (s_tdata[66:35]),
		.exponent       (s_tdata[98:67]),
		.cmd            (cmd),
		.sts            (sts),
		.result_value   (dp_result),
		.divide_by_zero (dp_dz)
	);

	// Output holding register: the valid flag is control state and is reset,
	// the payload is simply loaded with each finished item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_result_q <= dp_result;
			out_dz_q     <= dp_dz;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_result_q;
	assign m_tuser  = out_dz_q;

`ifndef NO_ASSERTIONS
	// Only one item is in work: the input side closes right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item was still in work");

	// A divide by zero always carries a zero quotient.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
		else $error("divide by zero flagged with a non-zero result");

	// The sequencer never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output register loaded while still holding an item");

	// Once a result is handed over, the sequencer is idle and open for input.
	a_load_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> s_tready)
		else $error("sequencer not idle after handing over a result");
`endif

endmodule
